FILE: hw/rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Types, constants and the lead byte decoder shared by the UTF-8 stream
// decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

  // field widths
  localparam int unsigned CpW   = 21;
  localparam int unsigned UsedW = 3;
  localparam int unsigned KindW = 3;

  // scalar value limits
  localparam logic [CpW-1:0] CpReplacement = 21'h00FFFD;
  localparam logic [CpW-1:0] CpSurrogateLo = 21'h00D800;
  localparam logic [CpW-1:0] CpSurrogateHi = 21'h00DFFF;
  localparam logic [CpW-1:0] CpMax         = 21'h10FFFF;
  localparam logic [CpW-1:0] CpMin2        = 21'h000080;
  localparam logic [CpW-1:0] CpMin3        = 21'h000800;
  localparam logic [CpW-1:0] CpMin4        = 21'h010000;

  // lead byte class boundaries
  localparam logic [7:0] ByteAsciiEnd = 8'h80;
  localparam logic [7:0] ByteLead2    = 8'hC0;
  localparam logic [7:0] ByteLead3    = 8'hE0;
  localparam logic [7:0] ByteLead4    = 8'hF0;
  localparam logic [7:0] ByteBadLead  = 8'hF8;

  // sequence lengths
  localparam logic [UsedW-1:0] Len1 = 3'd1;
  localparam logic [UsedW-1:0] Len2 = 3'd2;
  localparam logic [UsedW-1:0] Len3 = 3'd3;
  localparam logic [UsedW-1:0] Len4 = 3'd4;

  typedef enum logic [KindW-1:0] {
    ERR_NONE     = 3'd0,
    ERR_BAD_LEAD = 3'd1,
    ERR_BROKEN   = 3'd2,
    ERR_RANGE    = 3'd3,
    ERR_TRUNC    = 3'd4
  } err_kind_e;

  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic [UsedW-1:0] bytes_used;
    err_kind_e        error_kind;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic [CpW-1:0]   partial_value;
    logic [UsedW-1:0] expected_length;
    logic [UsedW-1:0] bytes_held;
  } seq_state_t;

  typedef struct packed {
    logic       emit;
    result_t    res;
    logic       start;
    seq_state_t seq;
  } lead_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
    seq_state_t seq;
  } dec_out_t;

  // decode a byte with no sequence open
  function automatic lead_t decode_lead(logic [7:0] b, logic eot);
    lead_t l;
    l = '0;
    if (b < ByteAsciiEnd) begin
      l.emit = 1'b1;
      l.res.code_point = {13'd0, b};
      l.res.bytes_used = Len1;
      l.res.error_kind = ERR_NONE;
    end else if (b < ByteLead2 || b >= ByteBadLead) begin
      l.emit = 1'b1;
      l.res.code_point = CpReplacement;
      l.res.bytes_used = Len1;
      l.res.error_kind = ERR_BAD_LEAD;
    end else if (eot) begin
      l.emit = 1'b1;
      l.res.code_point = CpReplacement;
      l.res.bytes_used = Len1;
      l.res.error_kind = ERR_TRUNC;
    end else begin
      l.start = 1'b1;
      l.seq.bytes_held = Len1;
      if (b < ByteLead3) begin
        l.seq.expected_length = Len2;
        l.seq.partial_value = {16'd0, b[4:0]};
      end else if (b < ByteLead4) begin
        l.seq.expected_length = Len3;
        l.seq.partial_value = {17'd0, b[3:0]};
      end else begin
        l.seq.expected_length = Len4;
        l.seq.partial_value = {18'd0, b[2:0]};
      end
    end
    return l;
  endfunction

endpackage

FILE: hw/rtl/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Streaming UTF-8 decoder: one text byte in, code points with error kinds out.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (low bit up)                      | tlast
//  s_axis   | in  | text_byte[7:0]                                 | end_of_text
//  m_axis   | out | code_point[20:0] bytes_used[23:21] kind[26:24] | last_of_run
//
//  one byte per clock while the queue has room: a byte is held in the input register,
//  then the decode step writes its zero, one or two results into the result queue
//  a byte that ends a broken sequence and decodes itself yields two results,
//  so the output side, one result per cycle while m_axis_tready holds, sets the long-run rate there
//  the input register drains only while the queue has two free entries
//  reset clears the open sequence, the input register and the queue
//  a stalled output holds its result; input keeps flowing until fewer than
//  two queue entries are free
module utf8_stream_decoder_unit #(
  parameter int unsigned ResultDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // code_point[20:0], bytes_used[23:21],
                                      // error_kind[26:24], zero pad
  output logic        m_axis_tlast
);
  import u8d_pkg::*;

  localparam int unsigned PtrW = (ResultDepth > 2) ? $clog2(ResultDepth) : 1;
  localparam int unsigned CntW = $clog2(ResultDepth + 1);
  localparam logic [PtrW-1:0] LastIdx  = PtrW'(ResultDepth - 1);
  localparam logic [CntW-1:0] RoomMark = CntW'(ResultDepth - 2);

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  seq_state_t seq_q, seq_d;
  dec_out_t   dec;
  logic       consume, s_xfer, pop;

  result_t        mem_q [ResultDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_p1, wptr_p2;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      push_n;
  result_t         head;

  // input register handshake
  assign consume       = in_valid_q && (count_q <= RoomMark);
  assign s_axis_tready = !in_valid_q || consume;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_xfer ? 1'b1 : (consume ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
  end

  // decode step
  u8d_decode u_decode (
    .byte_i (in_byte_q),
    .eot_i  (in_eot_q),
    .seq_i  (seq_q),
    .dec_o  (dec)
  );

  assign seq_d  = consume ? dec.seq : seq_q;
  assign push_n = consume ? dec.num : 2'd0;

  // result queue
  assign pop     = m_axis_tvalid && m_axis_tready;
  assign wptr_p1 = ptr_inc(wptr_q);
  assign wptr_p2 = ptr_inc(wptr_p1);
  assign rptr_d  = pop ? ptr_inc(rptr_q) : rptr_q;
  assign count_d = count_q + CntW'(push_n) - CntW'(pop);

  always_comb begin
    case (push_n)
      2'd1:    wptr_d = wptr_p1;
      2'd2:    wptr_d = wptr_p2;
      default: wptr_d = wptr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wptr_q] <= dec.res0;
    end
    if (push_n == 2'd2) begin
      mem_q[wptr_p1] <= dec.res1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      seq_q      <= '0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      count_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      seq_q      <= seq_d;
      wptr_q     <= wptr_d;
      rptr_q     <= rptr_d;
      count_q    <= count_d;
    end
  end

  // output side
  assign head          = mem_q[rptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {5'd0, head.error_kind, head.bytes_used, head.code_point};
  assign m_axis_tlast  = head.last_of_run;

endmodule

FILE: hw/rtl/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode
// Combinational step of the decoder: one byte plus the open sequence gives
// up to two results and the next sequence state.
// ----------------------------------------------------------------------------
module u8d_decode (
  input  logic [7:0]          byte_i,
  input  logic                eot_i,
  input  u8d_pkg::seq_state_t seq_i,
  output u8d_pkg::dec_out_t   dec_o
);
  import u8d_pkg::*;

  logic             open;
  lead_t            lead;
  logic [UsedW-1:0] held_inc;
  logic [CpW-1:0]   pv_new;
  logic [CpW-1:0]   min_val;

  assign open = (seq_i.expected_length != '0) && (seq_i.bytes_held != '0) &&
                (seq_i.bytes_held < seq_i.expected_length);
  assign lead     = decode_lead(byte_i, eot_i);
  assign held_inc = seq_i.bytes_held + 3'd1;
  assign pv_new   = {seq_i.partial_value[CpW-7:0], byte_i[5:0]};

  // smallest value that a sequence of this length may carry
  always_comb begin
    case (seq_i.expected_length)
      Len2:    min_val = CpMin2;
      Len3:    min_val = CpMin3;
      default: min_val = CpMin4;
    endcase
  end

  always_comb begin
    dec_o = '0;
    if (!open) begin
      // fresh lead byte
      if (lead.emit) begin
        dec_o.num = 2'd1;
        dec_o.res0 = lead.res;
        dec_o.res0.last_of_run = 1'b1;
      end else if (lead.start) begin
        dec_o.seq = lead.seq;
      end
    end else if (byte_i[7:6] == 2'b10) begin
      // continuation byte
      if (held_inc == seq_i.expected_length) begin
        dec_o.num = 2'd1;
        dec_o.res0.bytes_used = seq_i.expected_length;
        dec_o.res0.last_of_run = 1'b1;
        if (pv_new < min_val || pv_new > CpMax ||
            (pv_new >= CpSurrogateLo && pv_new <= CpSurrogateHi)) begin
          dec_o.res0.code_point = CpReplacement;
          dec_o.res0.error_kind = ERR_RANGE;
        end else begin
          dec_o.res0.code_point = pv_new;
          dec_o.res0.error_kind = ERR_NONE;
        end
      end else if (eot_i) begin
        dec_o.num = 2'd1;
        dec_o.res0.code_point = CpReplacement;
        dec_o.res0.bytes_used = held_inc;
        dec_o.res0.error_kind = ERR_TRUNC;
        dec_o.res0.last_of_run = 1'b1;
      end else begin
        dec_o.seq.partial_value = pv_new;
        dec_o.seq.expected_length = seq_i.expected_length;
        dec_o.seq.bytes_held = held_inc;
      end
    end else begin
      // broken sequence, then the byte again as a lead
      dec_o.num = 2'd1;
      dec_o.res0.code_point = CpReplacement;
      dec_o.res0.bytes_used = seq_i.bytes_held;
      dec_o.res0.error_kind = ERR_BROKEN;
      if (lead.emit) begin
        dec_o.num = 2'd2;
        dec_o.res1 = lead.res;
        dec_o.res1.last_of_run = 1'b1;
      end else begin
        dec_o.res0.last_of_run = 1'b1;
        if (lead.start) begin
          dec_o.seq = lead.seq;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks on the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import u8d_pkg::*;

  logic [CpW-1:0]   cp;
  logic [UsedW-1:0] used;
  logic [KindW-1:0] kind;

  assign cp   = m_axis_tdata[20:0];
  assign used = m_axis_tdata[23:21];
  assign kind = m_axis_tdata[26:24];

  // a stalled input transfer holds
  property p_in_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      s_axis_tvalid && !s_axis_tready |=>
        s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast);
  endproperty
  a_in_hold: assert property (p_in_hold) else $error("input changed while stalled");

  // a stalled result holds
  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

  // every error carries the replacement character
  property p_err_repl;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && (kind != ERR_NONE) |-> (cp == CpReplacement);
  endproperty
  a_err_repl: assert property (p_err_repl) else $error("error without U+FFFD");

  // a good result is a scalar value of the length it claims
  property p_ok_value;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && (kind == ERR_NONE) |->
        (cp <= CpMax) && !(cp >= CpSurrogateLo && cp <= CpSurrogateHi) &&
        ((used == Len1 && cp < CpMin2) || (used == Len2 && cp >= CpMin2 && cp < CpMin3) ||
         (used == Len3 && cp >= CpMin3 && cp < CpMin4) || (used == Len4 && cp >= CpMin4));
  endproperty
  a_ok_value: assert property (p_ok_value) else $error("bad decoded value");

  // a result that is not last of its byte is a broken sequence
  property p_not_last_broken;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tlast |-> (kind == ERR_BROKEN) && (used != '0);
  endproperty
  a_not_last_broken: assert property (p_not_last_broken)
    else $error("early result of a byte is not a broken sequence");

endmodule

bind utf8_stream_decoder_unit u8d_checker u_u8d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/tb_utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_unit
// Self-checking bench for the UTF-8 stream decoder. Feeds hand-picked byte
// runs followed by random well-formed and malformed sequences, predicts every
// code point in a scoreboard and compares each output transfer field by field
// while both sides idle at varying rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_unit;
  import u8d_pkg::*;

  // expected code points, predicted from the accepted bytes
  class code_point_scoreboard;
    logic [CpW-1:0]   partial;
    logic [UsedW-1:0] want_len;
    logic [UsedW-1:0] held;
    result_t          pending_cps[$];
    int               mismatches;
    int               checked;
    int               flagged;

    function new();
      clear_seq();
      mismatches = 0;
      checked    = 0;
      flagged    = 0;
    endfunction

    function void clear_seq();
      partial  = '0;
      want_len = '0;
      held     = '0;
    endfunction

    function void add(logic [CpW-1:0] cp, logic [UsedW-1:0] used, err_kind_e kind);
      result_t r;
      r = '0;
      r.code_point  = cp;
      r.bytes_used  = used;
      r.error_kind  = kind;
      pending_cps.push_back(r);
      if (kind != ERR_NONE) flagged++;
    endfunction

    // byte with no sequence open; returns 1 when it yields a result
    function bit decode_lead(logic [7:0] b, logic eot);
      if (b < 8'h80) begin
        add({13'd0, b}, Len1, ERR_NONE);
        return 1'b1;
      end
      if (b < 8'hC0 || b >= 8'hF8) begin
        add(CpReplacement, Len1, ERR_BAD_LEAD);
        return 1'b1;
      end
      if (eot) begin
        add(CpReplacement, Len1, ERR_TRUNC);
        clear_seq();
        return 1'b1;
      end
      held = Len1;
      if (b < 8'hE0) begin
        want_len = Len2;
        partial  = {16'd0, b[4:0]};
      end else if (b < 8'hF0) begin
        want_len = Len3;
        partial  = {17'd0, b[3:0]};
      end else begin
        want_len = Len4;
        partial  = {18'd0, b[2:0]};
      end
      return 1'b0;
    endfunction

    // one accepted byte: queue the results it causes
    function void decode_byte(logic [7:0] b, logic eot);
      int               n_before;
      logic [CpW-1:0]   lo;
      n_before = pending_cps.size();
      if (want_len == 0 || held == 0 || held >= want_len) begin
        clear_seq();
        void'(decode_lead(b, eot));
      end else if (b[7:6] == 2'b10) begin
        partial = {partial[CpW-7:0], b[5:0]};
        held    = held + 1'b1;
        if (held == want_len) begin
          lo = (want_len == Len2) ? CpMin2 : (want_len == Len3) ? CpMin3 : CpMin4;
          if (partial < lo || partial > CpMax ||
              (partial >= CpSurrogateLo && partial <= CpSurrogateHi))
            add(CpReplacement, want_len, ERR_RANGE);
          else
            add(partial, want_len, ERR_NONE);
          clear_seq();
        end else if (eot) begin
          add(CpReplacement, held, ERR_TRUNC);
          clear_seq();
        end
      end else begin
        // broken sequence, then the byte starts over as a lead
        add(CpReplacement, held, ERR_BROKEN);
        clear_seq();
        void'(decode_lead(b, eot));
      end
      // last result caused by this byte carries the run marker
      if (pending_cps.size() > n_before)
        pending_cps[pending_cps.size()-1].last_of_run = 1'b1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // one output transfer against the oldest expectation
    function void check_result(logic [31:0] data, logic last);
      result_t want;
      if (pending_cps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual cp %0h used %0d kind %0d",
                 $time, data[20:0], data[23:21], data[26:24]);
        mismatches++;
        return;
      end
      want = pending_cps.pop_front();
      checked++;
      compare_field("code_point", want.code_point, data[20:0]);
      compare_field("bytes_used", want.bytes_used, data[23:21]);
      compare_field("error_kind", want.error_kind, data[26:24]);
      compare_field("last_of_run", want.last_of_run, last);
    endfunction

    function int pending();
      return pending_cps.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  code_point_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int n_bytes   = 0;

  // {end_of_text, text_byte}
  logic [8:0] directed_run [25] = '{
    9'h000, 9'h080, 9'h0FF,                 // ascii low, stray continuation, bad lead
    9'h0C3, 9'h0A9,                         // two-byte character
    9'h0E2, 9'h082, 9'h0AC,                 // three-byte character
    9'h0C0, 9'h080,                         // overlong two-byte form
    9'h0ED, 9'h0A0, 9'h080,                 // surrogate
    9'h0F5, 9'h080, 9'h080, 9'h080,         // above the scalar range
    9'h0C3, 9'h041,                         // broken sequence, then ascii
    9'h0E2, 9'h182,                         // end of text mid-sequence
    9'h1C3,                                 // end of text on a lead
    9'h141,                                 // end of text on a complete item
    9'h0E2, 9'h0FF                          // broken sequence, then bad lead
  };

  utf8_stream_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // output side: check each transfer, then pick the next ready value
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // one byte transfer with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.decode_byte(b, eot);
    n_bytes++;
  endtask

  // utf-8 bytes of cp in n bytes, first byte lowest; no range check
  function automatic logic [31:0] utf8_bytes(logic [20:0] cp, int n);
    case (n)
      1:       return {24'd0, 1'b0, cp[6:0]};
      2:       return {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      3:       return {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      default: return {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                       5'b11110, cp[20:18]};
    endcase
  endfunction

  // random value in a range, with a bias toward its ends
  function automatic logic [20:0] pick_cp(int unsigned lo, int unsigned hi);
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 21'(lo) : 21'(hi);
    return 21'($urandom_range(hi, lo));
  endfunction

  // one random character or malformed fragment
  task automatic send_unit();
    logic [7:0]  run_bytes[$];
    logic [31:0] w;
    logic [20:0] cp;
    logic [7:0]  b;
    int          pick, n, keep, i;
    logic        trunc;
    trunc = 1'b0;
    pick  = $urandom_range(99);
    n     = $urandom_range(4, 2);
    if (pick < 60) begin
      n = $urandom_range(4, 1);
      case (n)
        1:       cp = pick_cp(0, 'h7F);
        2:       cp = pick_cp('h80, 'h7FF);
        3:       cp = pick_cp('h800, 'hFFFF);
        default: cp = pick_cp('h10000, 'h10FFFF);
      endcase
    end else if (pick < 66) begin
      // overlong forms
      cp = (n == 2) ? pick_cp(0, 'h7F) : (n == 3) ? pick_cp(0, 'h7FF) : pick_cp(0, 'hFFFF);
    end else if (pick < 70) begin
      n  = 3;
      cp = pick_cp('hD800, 'hDFFF);
    end else if (pick < 74) begin
      n  = 4;
      cp = pick_cp('h110000, 'h1FFFFF);
    end else if (pick < 79) begin
      n  = 0;
      run_bytes.push_back(8'($urandom_range('hBF, 'h80)));
    end else if (pick < 83) begin
      n  = 0;
      run_bytes.push_back(8'($urandom_range('hFF, 'hF8)));
    end else if (pick < 95) begin
      // broken or truncated: open a sequence and leave it unfinished
      cp = (n == 2) ? pick_cp('h80, 'h7FF) : (n == 3) ? pick_cp('h800, 'hFFFF)
                                                      : pick_cp('h10000, 'h10FFFF);
      w    = utf8_bytes(cp, n);
      keep = $urandom_range(n - 1, 1);
      for (i = 0; i < keep; i++) run_bytes.push_back(w[8*i +: 8]);
      if (pick < 90) begin
        b = 8'($urandom_range(255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        run_bytes.push_back(b);
      end else begin
        trunc = 1'b1;
      end
      n = 0;
    end else begin
      n = 0;
      run_bytes.push_back(8'($urandom_range(255)));
    end
    if (n != 0) begin
      w = utf8_bytes(cp, n);
      for (i = 0; i < n; i++) run_bytes.push_back(w[8*i +: 8]);
    end
    for (i = 0; i < run_bytes.size(); i++)
      send_byte(run_bytes[i], (trunc && i == run_bytes.size() - 1) ||
                              ($urandom_range(24) == 0));
  endtask

  // main sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles lightly, receiver heavily
    send_idle = 10;
    recv_idle = 51;
    foreach (directed_run[i]) send_byte(directed_run[i][7:0], directed_run[i][8]);
    while (n_bytes < 240) send_unit();

    // sender idles heavily, receiver lightly
    send_idle = 51;
    recv_idle = 10;
    while (n_bytes < 470) send_unit();

    // full rate on both sides
    send_idle = 0;
    recv_idle = 0;
    while (n_bytes < 700) send_unit();
    s_axis_tvalid <= 1'b0;

    // drain, then watch for stray results
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run covered %0d bytes and %0d checked code points, %0d of them flagged",
             n_bytes, sb.checked, sb.flagged);
    $display("mismatches: %0d, left over: %0d", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
